// ===== design/rbd_pkg.sv =====
package rbd_pkg;

  // Field widths of the command and result words
  localparam int CMD_W   = 4;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 9;

  // Default geometry of the ring
  localparam int DEF_DEPTH      = 256;
  localparam int DEF_DATA_WIDTH = 32;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_PEEK_FRONT = 4'd2,
    CMD_PEEK_BACK  = 4'd3,
    CMD_POP_FRONT  = 4'd4,
    CMD_POP_BACK   = 4'd5,
    CMD_CLEAR      = 4'd6,
    CMD_SEARCH     = 4'd7,
    CMD_REVERSE    = 4'd8
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } stat_e;

  // Address source of memory read port A
  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_LAST = 2'd1,
    RD_SCAN = 2'd2,
    RD_LO   = 2'd3
  } rd_sel_e;

  // Command word
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] elem_value;
  } cmd_word_t;

  // Result word
  typedef struct packed {
    logic [VALUE_W-1:0] out_value;
    logic [1:0]         status;
    logic               found;
    logic [COUNT_W-1:0] fill_count;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    clear;
    logic    rd_a_en;
    logic    rd_b_en;
    rd_sel_e rd_sel;
    logic    scan_init;
    logic    scan_step;
    logic    rev_init;
    logic    rev_wr_lo;
    logic    rev_wr_hi;
    logic    res_load;
    stat_e   res_status;
    logic    res_data;
    logic    res_found;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_more;
    logic scan_end;
    logic hit;
    logic rev_end;
  } dp_stat_t;

endpackage

// ===== design/ring_buffer_deque.sv =====
// Channel   Handshake                 Word                  Direction
// command   start / busy              item   (cmd_word_t)   in
// result    done (one-cycle strobe)   result (result_t)     out
//
// A word is taken at a rising edge with start high and busy low; its result is registered
// on the result port and marked by done, which is high for a single cycle.
// Push, clear, unused codes and full/empty refusals keep busy low: one word per cycle.
// Peek and pop wait for the registered memory read. Search reads one entry per cycle
// until a hit or the end; reverse reads each pair, then writes its low and high entry
// in turn, bound by the single memory write port. The result side cannot stall.
// Synchronous reset clears pointers and count; DEPTH must be a power of two.
module ring_buffer_deque #(
  parameter int DEPTH      = rbd_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = rbd_pkg::DEF_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rbd_pkg::cmd_word_t item,
  output logic               busy,
  output logic               done,
  output rbd_pkg::result_t   result
);
  import rbd_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  rbd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (item.cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  rbd_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .item (item),
    .stat (stat),
    .res  (result)
  );

endmodule

// ===== design/rbd_dpath.sv =====
module rbd_dpath #(
  parameter int DEPTH      = rbd_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = rbd_pkg::DEF_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  rbd_pkg::ctrl_cmd_t ctl,
  input  rbd_pkg::cmd_word_t item,
  output rbd_pkg::dp_stat_t  stat,
  output rbd_pkg::result_t   res
);
  import rbd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]         head, tail, head_next, tail_next, last;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         idx;
  logic                  pend;
  logic [AW-1:0]         lo, hi, pairs;
  logic [DATA_WIDTH-1:0] key, in_val, rd_a, rd_b, wr_data;
  logic [AW-1:0]         wr_addr, ra_addr;
  logic                  wr_en;
  logic [63:0]           in_ext, rd_ext;
  logic [31:0]           cnt_ext;

  // Resize the incoming word to the stored width and the read word to the value width
  assign in_ext  = 64'(item.elem_value);
  assign in_val  = in_ext[DATA_WIDTH-1:0];
  assign rd_ext  = 64'(rd_a);
  assign cnt_ext = 32'(count_next);
  assign last    = tail - AW'(1);

  // Advance head, tail and count
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    priority if (ctl.clear) begin
      head_next  = '0;
      tail_next  = '0;
      count_next = '0;
    end else if (ctl.push_front) begin
      head_next  = head - AW'(1);
      count_next = count + CW'(1);
    end else if (ctl.push_back) begin
      tail_next  = tail + AW'(1);
      count_next = count + CW'(1);
    end else if (ctl.pop_front) begin
      head_next  = head + AW'(1);
      count_next = count - CW'(1);
    end else if (ctl.pop_back) begin
      tail_next  = last;
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Select the write port
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = tail;
    wr_data = in_val;
    priority if (ctl.push_front) begin
      wr_addr = head - AW'(1);
    end else if (ctl.push_back) begin
      wr_addr = tail;
    end else if (ctl.rev_wr_lo) begin
      wr_addr = lo;
      wr_data = rd_b;
    end else if (ctl.rev_wr_hi) begin
      wr_addr = hi;
      wr_data = rd_a;
    end else begin
      wr_en = 1'b0;
    end
  end

  // Select the read port A address
  always_comb begin
    unique case (ctl.rd_sel)
      RD_HEAD: ra_addr = head;
      RD_LAST: ra_addr = last;
      RD_SCAN: ra_addr = head + idx[AW-1:0];
      RD_LO:   ra_addr = lo;
      default: ra_addr = head;
    endcase
  end

  // Entry memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_a_en) begin
      rd_a <= mem[ra_addr];
    end
    if (ctl.rd_b_en) begin
      rd_b <= mem[hi];
    end
  end

  // Walk the entries for a search, one read issued per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      pend <= 1'b0;
    end else if (ctl.scan_init) begin
      idx  <= '0;
      pend <= 1'b0;
    end else if (ctl.scan_step) begin
      idx  <= idx + CW'(stat.scan_more);
      pend <= stat.scan_more;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_init) begin
      key <= in_val;
    end
  end

  // Move the swap pointers for a reverse inward, one pair at a time
  always_ff @(posedge clk) begin
    if (ctl.rev_init) begin
      lo    <= head;
      hi    <= last;
      pairs <= count[CW-1:1];
    end else if (ctl.rev_wr_hi) begin
      lo    <= lo + AW'(1);
      hi    <= hi - AW'(1);
      pairs <= pairs - AW'(1);
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = count[AW];
  assign stat.scan_more = (idx != count);
  assign stat.scan_end  = (idx == count) && !pend;
  assign stat.hit       = pend && (rd_a == key);
  assign stat.rev_end   = (pairs == '0);

  // Hold the result word
  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      res.out_value  <= ctl.res_data ? rd_ext[VALUE_W-1:0] : '0;
      res.status     <= ctl.res_status;
      res.found      <= ctl.res_found;
      res.fill_count <= cnt_ext[COUNT_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds ring depth");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (AW'(tail - head) == count[AW-1:0]))
    else $error("head, tail and count disagree");

  a_ptr_hold_rev: assert property (@(posedge clk) disable iff (rst)
    ctl.rev_wr_lo |=> (head == $past(head)) && (tail == $past(tail)))
    else $error("pointers moved during reverse");
`endif

endmodule

// ===== design/rbd_ctrl.sv =====
module rbd_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rbd_pkg::CMD_W-1:0]  cmd,
  input  rbd_pkg::dp_stat_t          stat,
  output rbd_pkg::ctrl_cmd_t         ctl,
  output logic                       busy,
  output logic                       done
);
  import rbd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_PEEK    = 6'b000010,
    S_SEARCH  = 6'b000100,
    S_REV_RD  = 6'b001000,
    S_REV_WLO = 6'b010000,
    S_REV_WHI = 6'b100000
  } state_t;

  state_t state, state_next;

  // Decode state and command into datapath controls
  always_comb begin
    ctl            = '0;
    ctl.rd_sel     = RD_HEAD;
    ctl.res_status = ST_OK;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              ctl.res_load = 1'b1;
              if (stat.full) begin
                ctl.res_status = ST_FULL;
              end else begin
                ctl.push_front = (cmd == CMD_PUSH_FRONT);
                ctl.push_back  = (cmd == CMD_PUSH_BACK);
              end
            end
            CMD_PEEK_FRONT, CMD_PEEK_BACK, CMD_POP_FRONT, CMD_POP_BACK: begin
              if (stat.empty) begin
                ctl.res_load   = 1'b1;
                ctl.res_status = ST_EMPTY;
              end else begin
                ctl.rd_a_en   = 1'b1;
                ctl.rd_sel    = (cmd == CMD_PEEK_FRONT || cmd == CMD_POP_FRONT) ?
                                RD_HEAD : RD_LAST;
                ctl.pop_front = (cmd == CMD_POP_FRONT);
                ctl.pop_back  = (cmd == CMD_POP_BACK);
                state_next    = S_PEEK;
              end
            end
            CMD_CLEAR: begin
              ctl.clear    = 1'b1;
              ctl.res_load = 1'b1;
            end
            CMD_SEARCH: begin
              ctl.scan_init = 1'b1;
              state_next    = S_SEARCH;
            end
            CMD_REVERSE: begin
              ctl.rev_init = 1'b1;
              state_next   = S_REV_RD;
            end
            default: begin
              ctl.res_load = 1'b1;
            end
          endcase
        end
      end
      S_PEEK: begin
        ctl.res_load = 1'b1;
        ctl.res_data = 1'b1;
        state_next   = S_IDLE;
      end
      S_SEARCH: begin
        ctl.scan_step = 1'b1;
        ctl.rd_sel    = RD_SCAN;
        ctl.rd_a_en   = stat.scan_more;
        if (stat.hit || stat.scan_end) begin
          ctl.res_load  = 1'b1;
          ctl.res_found = stat.hit;
          state_next    = S_IDLE;
        end
      end
      S_REV_RD: begin
        if (stat.rev_end) begin
          ctl.res_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          ctl.rd_sel  = RD_LO;
          ctl.rd_a_en = 1'b1;
          ctl.rd_b_en = 1'b1;
          state_next  = S_REV_WLO;
        end
      end
      S_REV_WLO: begin
        ctl.rev_wr_lo = 1'b1;
        state_next    = S_REV_WHI;
      end
      S_REV_WHI: begin
        ctl.rev_wr_hi = 1'b1;
        state_next    = S_REV_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.res_load;
    end
  end

`ifndef ASSERT_OFF
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy raised without an accepted word");

  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_REV_WLO) |=> (state == S_REV_WHI))
    else $error("reverse swap lost its second write");

  a_no_result_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.res_load |=> (state == S_IDLE) && done)
    else $error("result issued while work continues");
`endif

endmodule
